>>> rtl/dlp_pkg.sv
// Shared types, symbol tables and codes for the DEFLATE length/distance code packer.
package dlp_pkg;

  localparam int LEN_SYMS     = 29;
  localparam int DIST_SYMS    = 30;
  localparam int WINDOW_SIZE  = 32768;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SYM_W    = 5;
  localparam int CODE_W   = 15;
  localparam int CLEN_W   = 4;
  localparam int VALUE_W  = 16;
  localparam int EXTRA_W  = 13;
  localparam int XCNT_W   = 4;
  localparam int PACKED_W = 28;
  localparam int PLEN_W   = 5;

  localparam int MIN_LENGTH = 3;
  localparam int MAX_LENGTH = 258;
  localparam int MIN_DIST   = 1;

  // Item modes as seen on the input port
  typedef enum logic [1:0] {
    MODE_LOAD_LEN  = 2'd0,
    MODE_LOAD_DIST = 2'd1,
    MODE_ENC_LEN   = 2'd2,
    MODE_ENC_DIST  = 2'd3
  } mode_t;

  // Operations carried through the queue
  typedef enum logic [2:0] {
    OP_LOAD_LEN,
    OP_LOAD_DIST,
    OP_ENC_LEN,
    OP_ENC_DIST,
    OP_RANGE_ERR
  } op_t;

  typedef struct packed {
    mode_t                mode;
    logic [SYM_W-1:0]     symbol_index;
    logic [CODE_W-1:0]    huffman_code;
    logic [CLEN_W-1:0]    huffman_length;
    logic [VALUE_W-1:0]   match_value;
  } item_t;

  typedef struct packed {
    logic [PACKED_W-1:0]  packed_bits;
    logic [PLEN_W-1:0]    packed_length;
    logic                 out_of_range;
  } result_t;

  // One stored Huffman code: length above the code bits
  typedef struct packed {
    logic [CLEN_W-1:0]    clen;
    logic [CODE_W-1:0]    code;
  } code_entry_t;

  // Classified item: a load carries the code, an encode the symbol and extra bits
  typedef struct packed {
    op_t                  op;
    logic [SYM_W-1:0]     idx;
    code_entry_t          code;
    logic [EXTRA_W-1:0]   extra_val;
    logic [XCNT_W-1:0]    extra_n;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam logic [8:0] LEN_BASE [LEN_SYMS] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };

  localparam logic [XCNT_W-1:0] LEN_EXTRA [LEN_SYMS] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd0
  };

  localparam logic [14:0] DIST_BASE [DIST_SYMS] = '{
    15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17, 15'd25,
    15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193, 15'd257, 15'd385, 15'd513,
    15'd769, 15'd1025, 15'd1537, 15'd2049, 15'd3073, 15'd4097, 15'd6145,
    15'd8193, 15'd12289, 15'd16385, 15'd24577
  };

  localparam logic [XCNT_W-1:0] DIST_EXTRA [DIST_SYMS] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

endpackage

>>> rtl/deflate_length_distance_code_packer_unit.sv
// Top level of the DEFLATE length/distance code packer.
// The block takes one item per clock: a transfer happens when start is high and busy is low.
// Load items write a Huffman code into the length store (29 entries) or the distance
// store (30 entries) and give no result; encode items give exactly one result, shown
// with done for a single cycle once it has passed the queue slot and the result register,
// in item order.
// The front end classifies the value into its symbol and extra bits in the transfer
// cycle, a two-entry queue hands it to the back end, which reads the code store and
// packs code and extra bits in the next cycle. Since results are never held off the
// queue drains every cycle and busy stays low, giving a sustained rate of one item per
// cycle. Both stores read as zero after reset through per-entry valid flags, so there
// is no clearing pass and the block can take items in the cycle after reset.
module deflate_length_distance_code_packer_unit import dlp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic      keep;
  logic      push;
  logic      pop;
  q_entry_t  front_entry;
  q_entry_t  head;
  q_status_t q_status;

  assign busy = q_status.full;
  assign push = start && !busy && keep;

  dlp_front u_front (
    .item  (item),
    .keep  (keep),
    .entry (front_entry)
  );

  dlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (front_entry),
    .pop      (pop),
    .rd_entry (head),
    .status   (q_status)
  );

  dlp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

endmodule

>>> rtl/dlp_front.sv
// Front end: classify an incoming item into a queue entry (symbol lookup, range check).
module dlp_front import dlp_pkg::*; (
  input  item_t    item,
  output logic     keep,
  output q_entry_t entry
);

  always_comb begin
    logic [SYM_W-1:0]   sym;
    logic [VALUE_W-1:0] diff;
    sym         = '0;
    diff        = '0;
    keep        = 1'b1;
    entry       = '0;
    entry.op    = OP_RANGE_ERR;
    unique case (item.mode)
      MODE_LOAD_LEN: begin
        // drop loads beyond the store
        entry.op        = OP_LOAD_LEN;
        entry.idx       = item.symbol_index;
        entry.code.code = item.huffman_code;
        entry.code.clen = item.huffman_length;
        keep            = item.symbol_index < SYM_W'(LEN_SYMS);
      end
      MODE_LOAD_DIST: begin
        entry.op        = OP_LOAD_DIST;
        entry.idx       = item.symbol_index;
        entry.code.code = item.huffman_code;
        entry.code.clen = item.huffman_length;
        keep            = item.symbol_index < SYM_W'(DIST_SYMS);
      end
      MODE_ENC_LEN: begin
        if (item.match_value < VALUE_W'(MIN_LENGTH) ||
            item.match_value > VALUE_W'(MAX_LENGTH)) begin
          entry.op = OP_RANGE_ERR;
        end else begin
          // the top length has a symbol of its own, no extra bits
          if (item.match_value == VALUE_W'(MAX_LENGTH)) begin
            sym = SYM_W'(LEN_SYMS - 1);
          end else begin
            for (int i = 0; i < LEN_SYMS - 1; i++) begin
              if (item.match_value >= VALUE_W'(LEN_BASE[i])) sym = SYM_W'(i);
            end
          end
          diff            = item.match_value - VALUE_W'(LEN_BASE[sym]);
          entry.op        = OP_ENC_LEN;
          entry.idx       = sym;
          entry.extra_val = diff[EXTRA_W-1:0];
          entry.extra_n   = LEN_EXTRA[sym];
        end
      end
      MODE_ENC_DIST: begin
        if (item.match_value < VALUE_W'(MIN_DIST) ||
            {1'b0, item.match_value} > (VALUE_W+1)'(WINDOW_SIZE)) begin
          entry.op = OP_RANGE_ERR;
        end else begin
          for (int i = 0; i < DIST_SYMS; i++) begin
            if (item.match_value >= VALUE_W'(DIST_BASE[i])) sym = SYM_W'(i);
          end
          diff            = item.match_value - VALUE_W'(DIST_BASE[sym]);
          entry.op        = OP_ENC_DIST;
          entry.idx       = sym;
          entry.extra_val = diff[EXTRA_W-1:0];
          entry.extra_n   = DIST_EXTRA[sym];
        end
      end
      default: begin
        entry.op = OP_RANGE_ERR;
      end
    endcase
  end

endmodule

>>> rtl/dlp_queue.sv
// Short FIFO of classified entries between the front and back ends.
module dlp_queue import dlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  wr_entry,
  input  logic      pop,
  output q_entry_t  rd_entry,
  output q_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_entry     = slots[rd_ptr];

  // store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/dlp_back.sv
// Back end: code stores, code lookup, bit packing and the result register.
module dlp_back import dlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  q_entry_t  head,
  output logic      pop,
  output logic      done,
  output result_t   result
);

  code_entry_t          len_store  [LEN_SYMS];
  code_entry_t          dist_store [DIST_SYMS];
  logic [LEN_SYMS-1:0]  len_vld;
  logic [DIST_SYMS-1:0] dist_vld;

  code_entry_t          ent;
  logic [CODE_W-1:0]    code_masked;
  result_t              result_next;
  logic                 emit;

  // take the head entry whenever one waits
  assign pop = !q_status.empty;

  // read the addressed entry; an entry never loaded reads as zero
  always_comb begin
    ent  = '0;
    emit = 1'b0;
    unique case (head.op)
      OP_ENC_LEN: begin
        emit = 1'b1;
        if (len_vld[head.idx]) ent = len_store[head.idx];
      end
      OP_ENC_DIST: begin
        emit = 1'b1;
        if (dist_vld[head.idx]) ent = dist_store[head.idx];
      end
      OP_RANGE_ERR: begin
        emit = 1'b1;
      end
      OP_LOAD_LEN, OP_LOAD_DIST: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // drop stray code bits, then place the extra bits above the code
  always_comb begin
    code_masked = ent.code & ~({CODE_W{1'b1}} << ent.clen);
    result_next = '0;
    if (head.op == OP_RANGE_ERR) begin
      result_next.out_of_range = 1'b1;
    end else begin
      result_next.packed_bits   = PACKED_W'(code_masked)
                                | (PACKED_W'(head.extra_val) << ent.clen);
      result_next.packed_length = PLEN_W'(ent.clen) + PLEN_W'(head.extra_n);
    end
  end

  // load the code stores in queue order
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_LOAD_LEN) len_store[head.idx] <= head.code;
    if (pop && head.op == OP_LOAD_DIST) dist_store[head.idx] <= head.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld  <= '0;
      dist_vld <= '0;
    end else begin
      if (pop && head.op == OP_LOAD_LEN) len_vld[head.idx] <= 1'b1;
      if (pop && head.op == OP_LOAD_DIST) dist_vld[head.idx] <= 1'b1;
    end
  end

  // register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) result <= result_next;
  end

endmodule

>>> rtl/dlp_checker.sv
// Port-level checks for the code packer, bound to the top level.
module dlp_checker import dlp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // no result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // a range error carries no bits
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.out_of_range |-> result.packed_bits == '0 && result.packed_length == '0)
    else $error("range error with payload");

  // nothing set above the packed length
  a_bits_fit: assert property (@(posedge clk) disable iff (rst)
    done && !result.out_of_range |-> (result.packed_bits >> result.packed_length) == '0)
    else $error("packed bits beyond packed length");

  // an encode transfer yields a result once it has passed the queue and the result register
  a_encode_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == MODE_ENC_LEN || item.mode == MODE_ENC_DIST)
    |-> ##2 done)
    else $error("encode without result");

  // a load transfer yields none
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == MODE_LOAD_LEN || item.mode == MODE_LOAD_DIST)
    |-> ##2 !done)
    else $error("load produced a result");

endmodule

bind deflate_length_distance_code_packer_unit dlp_checker u_dlp_checker (.*);
